>>> hdl/uart_rx_tx_ring_buffers_defines.svh
// Assertion macros for the checker file of the UART ring buffer block.
`ifndef UART_RX_TX_RING_BUFFERS_DEFINES_SVH
`define UART_RX_TX_RING_BUFFERS_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define UARTRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define UARTRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/uartrb_pkg.sv
// Types and constants shared by the UART ring buffer block.
`timescale 1ns / 1ps
`default_nettype none

package uartrb_pkg;

    typedef enum logic [1:0] {
        OP_HOST_WRITE = 2'd0,
        OP_HOST_READ  = 2'd1,
        OP_LINE_RX    = 2'd2,
        OP_TX_READY   = 2'd3
    } opcode_t;

    localparam int unsigned BYTE_W = 8;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

`default_nettype wire

>>> hdl/uartrb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module uartrb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/uart_rx_tx_ring_buffers.sv
// Top level of the UART receive and transmit ring buffers.
// The input channel (in_valid, in_ready, opcode, data_in) carries one event per word:
// a host write, a host read, a received line byte or a transmitter-ready event.
// The output channel (out_valid, out_ready and the result ports) returns exactly
// one result word for every accepted event, in order.
// The result of an event is registered at the edge that accepts it.
// Throughput is one event per cycle while results are taken; the ring state updates in the accepting cycle
// and each ring's RAM reads its head entry into its registered read port.
// A full or empty ring never stalls the input: a refused push is flagged, an empty pop returns no byte.
// When the receiver stalls, the result word holds and in_ready falls until it is taken.
// Reset empties both rings, zeroes the pointers and clears the interrupt enable;
// the ring storage itself is not cleared, and no pop can reach an unwritten entry.
`timescale 1ns / 1ps
`default_nettype none

module uart_rx_tx_ring_buffers #(
    parameter int unsigned RX_DEPTH = 64,
    parameter int unsigned TX_DEPTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire uartrb_pkg::opcode_t opcode,
    input  wire uartrb_pkg::byte_t data_in,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output uartrb_pkg::byte_t      read_data,
    output logic                   read_valid,
    output uartrb_pkg::byte_t      line_tx_data,
    output logic                   line_tx_valid,
    output logic                   write_refused,
    output logic                   rx_overflow,
    output logic                   rx_is_empty,
    output logic                   tx_is_empty,
    output logic                   tx_irq_enable
);

    import uartrb_pkg::*;

    localparam int unsigned RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int unsigned TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    logic [RX_AW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [TX_AW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [RX_AW-1:0] rx_head_inc, rx_tail_inc;
    logic [TX_AW-1:0] tx_head_inc, tx_tail_inc;
    logic rx_vacant_reg, rx_vacant_next;
    logic tx_vacant_reg, tx_vacant_next;
    logic tx_en_reg, tx_en_next;
    logic out_valid_reg, out_valid_next;
    logic rd_v_reg, rd_v_next;
    logic tx_v_reg, tx_v_next;
    logic refused_reg, refused_next;
    logic ovf_reg, ovf_next;
    logic accept;
    logic rx_full, tx_full;
    logic rx_we, rx_re, tx_we, tx_re;
    byte_t rx_rdata, tx_rdata;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign rx_full = !rx_vacant_reg && (rx_head_reg == rx_tail_reg);
    assign tx_full = !tx_vacant_reg && (tx_head_reg == tx_tail_reg);

    assign rx_head_inc = (rx_head_reg == RX_LAST) ? '0 : rx_head_reg + 1'b1;
    assign rx_tail_inc = (rx_tail_reg == RX_LAST) ? '0 : rx_tail_reg + 1'b1;
    assign tx_head_inc = (tx_head_reg == TX_LAST) ? '0 : tx_head_reg + 1'b1;
    assign tx_tail_inc = (tx_tail_reg == TX_LAST) ? '0 : tx_tail_reg + 1'b1;

    assign rx_we = accept && (opcode == OP_LINE_RX) && !rx_full;
    assign rx_re = accept && (opcode == OP_HOST_READ) && !rx_vacant_reg;
    assign tx_we = accept && (opcode == OP_HOST_WRITE) && !tx_full;
    assign tx_re = accept && (opcode == OP_TX_READY) && !tx_vacant_reg;

    always_comb
    begin
        rx_head_next   = rx_head_reg;
        rx_tail_next   = rx_tail_reg;
        tx_head_next   = tx_head_reg;
        tx_tail_next   = tx_tail_reg;
        rx_vacant_next = rx_vacant_reg;
        tx_vacant_next = tx_vacant_reg;
        tx_en_next     = tx_en_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rd_v_next      = rd_v_reg;
        tx_v_next      = tx_v_reg;
        refused_next   = refused_reg;
        ovf_next       = ovf_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            rd_v_next      = rx_re;
            tx_v_next      = tx_re;
            refused_next   = 1'b0;
            ovf_next       = 1'b0;
            case (opcode)
                OP_HOST_WRITE:
                begin
                    if (tx_full)
                    begin
                        refused_next = 1'b1;
                    end
                    else
                    begin
                        tx_tail_next   = tx_tail_inc;
                        tx_vacant_next = 1'b0;
                        tx_en_next     = 1'b1;
                    end
                end
                OP_HOST_READ:
                begin
                    if (!rx_vacant_reg)
                    begin
                        rx_head_next = rx_head_inc;
                        if (rx_head_inc == rx_tail_reg)
                        begin
                            rx_vacant_next = 1'b1;
                        end
                    end
                end
                OP_LINE_RX:
                begin
                    if (rx_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        rx_tail_next   = rx_tail_inc;
                        rx_vacant_next = 1'b0;
                    end
                end
                OP_TX_READY:
                begin
                    if (tx_vacant_reg)
                    begin
                        tx_en_next = 1'b0;
                    end
                    else
                    begin
                        tx_head_next = tx_head_inc;
                        if (tx_head_inc == tx_tail_reg)
                        begin
                            tx_vacant_next = 1'b1;
                            tx_en_next     = 1'b0;
                        end
                    end
                end
                default:
                begin
                    out_valid_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            rx_vacant_reg <= 1'b1;
            tx_vacant_reg <= 1'b1;
            tx_en_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_v_reg      <= 1'b0;
            tx_v_reg      <= 1'b0;
            refused_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            rx_head_reg   <= rx_head_next;
            rx_tail_reg   <= rx_tail_next;
            tx_head_reg   <= tx_head_next;
            tx_tail_reg   <= tx_tail_next;
            rx_vacant_reg <= rx_vacant_next;
            tx_vacant_reg <= tx_vacant_next;
            tx_en_reg     <= tx_en_next;
            out_valid_reg <= out_valid_next;
            rd_v_reg      <= rd_v_next;
            tx_v_reg      <= tx_v_next;
            refused_reg   <= refused_next;
            ovf_reg       <= ovf_next;
        end
    end

    uartrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_tail_reg),
        .wdata (data_in),
        .re    (rx_re),
        .raddr (rx_head_reg),
        .rdata (rx_rdata)
    );

    uartrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_tail_reg),
        .wdata (data_in),
        .re    (tx_re),
        .raddr (tx_head_reg),
        .rdata (tx_rdata)
    );

    // The ring state always belongs to the most recent accepted word, which is
    // the one held in the output register.
    assign out_valid     = out_valid_reg;
    assign read_valid    = rd_v_reg;
    assign read_data     = rd_v_reg ? rx_rdata : '0;
    assign line_tx_valid = tx_v_reg;
    assign line_tx_data  = tx_v_reg ? tx_rdata : '0;
    assign write_refused = refused_reg;
    assign rx_overflow   = ovf_reg;
    assign rx_is_empty   = rx_vacant_reg;
    assign tx_is_empty   = tx_vacant_reg;
    assign tx_irq_enable = tx_en_reg;

endmodule

`default_nettype wire

>>> hdl/uartrb_checker.sv
// Port-level checker for the UART ring buffer block and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "uart_rx_tx_ring_buffers_defines.svh"

module uartrb_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire uartrb_pkg::opcode_t opcode,
    input wire uartrb_pkg::byte_t data_in,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire uartrb_pkg::byte_t read_data,
    input wire logic              read_valid,
    input wire uartrb_pkg::byte_t line_tx_data,
    input wire logic              line_tx_valid,
    input wire logic              write_refused,
    input wire logic              rx_overflow,
    input wire logic              rx_is_empty,
    input wire logic              tx_is_empty,
    input wire logic              tx_irq_enable
);

    import uartrb_pkg::*;

    logic unused_ok;

    // A few inputs are only listed so that the bind can connect every port.
    assign unused_ok = ^{data_in, line_tx_data, rx_is_empty};

    // Every accepted word yields a result word in the next cycle.
    `UARTRB_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid, "accepted word produced no result")

    // A host write that is not refused leaves a non-empty transmit ring with the enable set.
    `UARTRB_ASSERT_NEXT(a_write_sets_enable, clk, rst_n, in_valid && in_ready && (opcode == OP_HOST_WRITE), write_refused || (!tx_is_empty && tx_irq_enable), "host write did not set the transmit enable")

    // A host read never shows a transmit byte, a refused write or a receive overflow.
    `UARTRB_ASSERT_NEXT(a_read_flags_clean, clk, rst_n, in_valid && in_ready && (opcode == OP_HOST_READ), !line_tx_valid && !write_refused && !rx_overflow, "host read raised an unrelated flag")

    // An empty read returns zero data.
    `UARTRB_ASSERT_NOW(a_read_data_zero, clk, rst_n, out_valid && !read_valid, read_data == '0, "read data not zero without a valid read")

    // Draining the transmit ring drops the interrupt enable.
    `UARTRB_ASSERT_NOW(a_drain_clears_enable, clk, rst_n, out_valid && line_tx_valid && tx_is_empty, !tx_irq_enable, "transmit enable still set after drain")

endmodule

bind uart_rx_tx_ring_buffers uartrb_checker u_uartrb_checker (.*);

`default_nettype wire

>>> tb/tb_uart_rx_tx_ring_buffers.sv
// Self-checking testbench for the UART receive and transmit ring buffers.
`timescale 1ns / 1ps

module tb_uart_rx_tx_ring_buffers;

    import uartrb_pkg::*;

    localparam int unsigned RX_DEPTH       = 64;
    localparam int unsigned TX_DEPTH       = 64;
    localparam int unsigned RANDOM_WORDS   = 750;
    localparam int unsigned BACKLOG_WORDS  = 60;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned IDLE_LIMIT     = 5000;
    localparam int unsigned TAIL_CYCLES    = 8;

    typedef struct packed {
        byte_t read_data;
        logic  read_valid;
        byte_t line_tx_data;
        logic  line_tx_valid;
        logic  write_refused;
        logic  rx_overflow;
        logic  rx_is_empty;
        logic  tx_is_empty;
        logic  tx_irq_enable;
    } uart_result_t;

    class ring_scoreboard;
        byte_t        rx_ring [RX_DEPTH];
        byte_t        tx_ring [TX_DEPTH];
        int unsigned  rx_head, rx_tail, tx_head, tx_tail;
        bit           rx_vacant, tx_vacant, tx_irq_en;
        uart_result_t expected_q [$];
        int unsigned  mismatches, checked, accepted;
        int unsigned  refused_writes, overflows, empty_reads, idle_tx;

        function new();
            rx_head   = 0;
            rx_tail   = 0;
            tx_head   = 0;
            tx_tail   = 0;
            rx_vacant = 1'b1;
            tx_vacant = 1'b1;
            tx_irq_en = 1'b0;
        endfunction

        function int unsigned next_slot(int unsigned slot, int unsigned depth);
            return (slot + 1 >= depth) ? 0 : slot + 1;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_word(opcode_t op, byte_t data);
            uart_result_t r;
            r = '0;
            accepted++;
            case (op)
                OP_HOST_WRITE:
                begin
                    if (!tx_vacant && tx_head == tx_tail)
                    begin
                        r.write_refused = 1'b1;
                        refused_writes++;
                    end
                    else
                    begin
                        tx_ring[tx_tail] = data;
                        tx_tail = next_slot(tx_tail, TX_DEPTH);
                        tx_vacant = 1'b0;
                        tx_irq_en = 1'b1;
                    end
                end
                OP_HOST_READ:
                begin
                    if (rx_vacant)
                    begin
                        empty_reads++;
                    end
                    else
                    begin
                        r.read_data = rx_ring[rx_head];
                        r.read_valid = 1'b1;
                        rx_head = next_slot(rx_head, RX_DEPTH);
                        if (rx_head == rx_tail)
                        begin
                            rx_vacant = 1'b1;
                        end
                    end
                end
                OP_LINE_RX:
                begin
                    if (!rx_vacant && rx_head == rx_tail)
                    begin
                        r.rx_overflow = 1'b1;
                        overflows++;
                    end
                    else
                    begin
                        rx_ring[rx_tail] = data;
                        rx_tail = next_slot(rx_tail, RX_DEPTH);
                        rx_vacant = 1'b0;
                    end
                end
                OP_TX_READY:
                begin
                    if (tx_vacant)
                    begin
                        tx_irq_en = 1'b0;
                        idle_tx++;
                    end
                    else
                    begin
                        r.line_tx_data = tx_ring[tx_head];
                        r.line_tx_valid = 1'b1;
                        tx_head = next_slot(tx_head, TX_DEPTH);
                        if (tx_head == tx_tail)
                        begin
                            tx_vacant = 1'b1;
                            tx_irq_en = 1'b0;
                        end
                    end
                end
            endcase
            r.rx_is_empty   = rx_vacant;
            r.tx_is_empty   = tx_vacant;
            r.tx_irq_enable = tx_irq_en;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("Mismatch at result %0d: %s", checked, what);
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
            begin
                report_mismatch($sformatf("%s is %02h, expected %02h", name, got, want));
            end
        endtask

        task check_result(uart_result_t got);
            uart_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result word with no event pending");
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("read_data", got.read_data, want.read_data);
            compare_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
            compare_field("line_tx_data", got.line_tx_data, want.line_tx_data);
            compare_field("line_tx_valid", 8'(got.line_tx_valid), 8'(want.line_tx_valid));
            compare_field("write_refused", 8'(got.write_refused), 8'(want.write_refused));
            compare_field("rx_overflow", 8'(got.rx_overflow), 8'(want.rx_overflow));
            compare_field("rx_is_empty", 8'(got.rx_is_empty), 8'(want.rx_is_empty));
            compare_field("tx_is_empty", 8'(got.tx_is_empty), 8'(want.tx_is_empty));
            compare_field("tx_irq_enable", 8'(got.tx_irq_enable), 8'(want.tx_irq_enable));
        endtask
    endclass

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    in_ready;
    opcode_t opcode    = OP_HOST_WRITE;
    byte_t   data_in   = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    byte_t   read_data;
    logic    read_valid;
    byte_t   line_tx_data;
    logic    line_tx_valid;
    logic    write_refused;
    logic    rx_overflow;
    logic    rx_is_empty;
    logic    tx_is_empty;
    logic    tx_irq_enable;

    ring_scoreboard sb = new();
    int unsigned    idle_cycles     = 0;
    bit             holdoff_pending = 1'b0;
    int unsigned    burst_left      = 0;

    uart_rx_tx_ring_buffers #(
        .RX_DEPTH(RX_DEPTH),
        .TX_DEPTH(TX_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .data_in      (data_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .read_valid   (read_valid),
        .line_tx_data (line_tx_data),
        .line_tx_valid(line_tx_valid),
        .write_refused(write_refused),
        .rx_overflow  (rx_overflow),
        .rx_is_empty  (rx_is_empty),
        .tx_is_empty  (tx_is_empty),
        .tx_irq_enable(tx_irq_enable)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin : monitor
        logic accepted_in;
        logic accepted_out;
        accepted_in  = in_valid && in_ready;
        accepted_out = out_valid && out_ready;
        if (accepted_in)
        begin
            sb.note_word(opcode, data_in);
        end
        if (accepted_out)
        begin
            sb.check_result({read_data, read_valid, line_tx_data, line_tx_valid,
                             write_refused, rx_overflow, rx_is_empty, tx_is_empty,
                             tx_irq_enable});
        end
        if (accepted_in || accepted_out || !rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
    end

    initial
    begin : receiver
        int unsigned mode;
        int unsigned mode_left;
        mode_left = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (holdoff_pending)
            begin
                holdoff_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("Watchdog: no word moved for %0d cycles, %0d results still pending",
                 IDLE_LIMIT, sb.pending());
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_word(opcode_t op, byte_t data);
        in_valid <= 1'b1;
        opcode   <= op;
        data_in  <= data;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    task automatic offer_word(opcode_t op, byte_t data);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_word(op, data);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic pick_word(int unsigned rx_push_pct, int unsigned tx_push_pct,
                             output opcode_t op, output byte_t data);
        bit to_rx;
        bit push;
        to_rx = 1'($urandom_range(0, 1));
        push  = $urandom_range(0, 99) < (to_rx ? rx_push_pct : tx_push_pct);
        if (to_rx)
        begin
            op = push ? OP_LINE_RX : OP_HOST_READ;
        end
        else
        begin
            op = push ? OP_HOST_WRITE : OP_TX_READY;
        end
        case ($urandom_range(0, 9))
            0: data = 8'h00;
            1: data = 8'hFF;
            default: data = byte_t'($urandom);
        endcase
    endtask

    function automatic int unsigned pick_push_pct();
        case ($urandom_range(0, 2))
            0: return 8;
            1: return 50;
            default: return 92;
        endcase
    endfunction

    initial
    begin : stimulus
        opcode_t     op;
        byte_t       data;
        int unsigned sent;
        int unsigned seg_len;
        int unsigned rx_pct;
        int unsigned tx_pct;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // From reset: empty read and transmit, then both rings take bytes and drain.
        offer_word(OP_HOST_READ, 8'h5A);
        offer_word(OP_TX_READY, 8'hFF);
        offer_word(OP_HOST_WRITE, 8'h00);
        offer_word(OP_HOST_WRITE, 8'hFF);
        offer_word(OP_HOST_WRITE, 8'hA5);
        offer_word(OP_TX_READY, 8'h00);
        offer_word(OP_LINE_RX, 8'hFF);
        offer_word(OP_LINE_RX, 8'h00);
        offer_word(OP_LINE_RX, 8'h5A);
        offer_word(OP_HOST_READ, 8'h00);
        offer_word(OP_HOST_READ, 8'hFF);
        offer_word(OP_HOST_READ, 8'h00);
        offer_word(OP_HOST_READ, 8'hFF);
        offer_word(OP_TX_READY, 8'h00);
        offer_word(OP_TX_READY, 8'h00);
        offer_word(OP_TX_READY, 8'hFF);
        offer_word(OP_HOST_WRITE, 8'h3C);
        offer_word(OP_TX_READY, 8'hC3);
        offer_word(OP_TX_READY, 8'h00);
        drain_results();

        // The receiver holds off while the sender keeps offering words back to back.
        holdoff_pending = 1'b1;
        for (sent = 0; sent < BACKLOG_WORDS; sent++)
        begin
            pick_word(92, 92, op, data);
            send_word(op, data);
        end

        seg_len = 200;
        rx_pct = 92;
        tx_pct = 92;
        while (sent < RANDOM_WORDS)
        begin
            for (int unsigned i = 0; i < seg_len && sent < RANDOM_WORDS; i++)
            begin
                pick_word(rx_pct, tx_pct, op, data);
                offer_word(op, data);
                sent++;
            end
            if (rx_pct == 92 && tx_pct == 92 && seg_len == 200)
            begin
                rx_pct = 8;
                tx_pct = 8;
            end
            else
            begin
                seg_len = $urandom_range(40, 160);
                rx_pct = pick_push_pct();
                tx_pct = pick_push_pct();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d events and checked %0d results across fill, drain and mixed traffic.",
                 sb.accepted, sb.checked);
        $display("Saw %0d refused writes, %0d overflows, %0d empty reads, %0d idle transmits.",
                 sb.refused_writes, sb.overflows, sb.empty_reads, sb.idle_tx);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> uart_rx_tx_ring_buffers.f
+incdir+hdl
hdl/uartrb_pkg.sv
hdl/uartrb_ram.sv
hdl/uart_rx_tx_ring_buffers.sv
hdl/uartrb_checker.sv
tb/tb_uart_rx_tx_ring_buffers.sv
